// File: rtl/e2b_pkg.sv
// ---------------------------------------------------------------------------
// e2b_pkg: shared constants, types and functions
// Holds the CORDIC arctangent table, fixed-point constants and stage types.
// ---------------------------------------------------------------------------
package e2b_pkg;

  localparam int CordicStepsDef = 16;
  localparam int OutFracBitsDef = 14;
  localparam int TabLen         = 24;
  localparam int AngW           = 16;
  localparam int OutW           = 16;
  // Q30 data with headroom: 34-bit signed for CORDIC x, y and z.
  localparam int DW             = 34;

  localparam logic signed [DW-1:0] GainQ30    = 34'sh026DD3B6A;
  localparam logic [28:0]          RadPerUnit = 29'd299845282;
  localparam int                   FullTurn   = 23040;
  localparam int                   QuarterTurn = 5760;

  typedef logic signed [DW-1:0] word_t;

  // One angle in flight through the CORDIC row.
  typedef struct packed {
    word_t      x;
    word_t      y;
    word_t      z;
    logic [1:0] quad;
  } rot_t;

  function automatic word_t atan_q30(input logic [4:0] i);
    word_t r;
    r = '0;
    case (i)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q30 by Q30 product, rounded half up back to Q30.
  function automatic word_t mulq(input word_t a, input word_t b);
    logic signed [2*DW-1:0] p;
    p = (2*DW)'(a) * (2*DW)'(b) + (2*DW)'(64'sd1 <<< 29);
    return DW'(p >>> 30);
  endfunction

endpackage

// File: rtl/e2b_prep.sv
// ---------------------------------------------------------------------------
// e2b_prep: angle reduction
// Wraps an angle into one turn, splits off the quadrant and forms the
// residual in radians (Q30) as the seed of a CORDIC row.
// ---------------------------------------------------------------------------
module e2b_prep (
  input  logic                           clk_i,
  input  logic signed [e2b_pkg::AngW-1:0] ang_i,
  output e2b_pkg::rot_t                  seed_o
);

  logic signed [17:0] r0;
  logic [14:0]        r;
  logic [12:0]        f;
  logic [1:0]         q;
  logic [41:0]        prod;
  logic [14:0]        r_q;

  // The input spans under three turns either side, so a short chain of
  // compares folds it into 0..23039.
  always_comb begin
    r0 = 18'(ang_i);
    if (r0 < 0) r0 = r0 + 18'(e2b_pkg::FullTurn);
    if (r0 < 0) r0 = r0 + 18'(e2b_pkg::FullTurn);
    if (r0 >= 18'(e2b_pkg::FullTurn)) r0 = r0 - 18'(e2b_pkg::FullTurn);
    r = r0[14:0];
  end

  always_ff @(posedge clk_i) begin
    r_q <= r;
  end

  always_comb begin
    if (r_q >= 15'(3*e2b_pkg::QuarterTurn)) begin
      q = 2'd3; f = 13'(r_q - 15'(3*e2b_pkg::QuarterTurn));
    end else if (r_q >= 15'(2*e2b_pkg::QuarterTurn)) begin
      q = 2'd2; f = 13'(r_q - 15'(2*e2b_pkg::QuarterTurn));
    end else if (r_q >= 15'(e2b_pkg::QuarterTurn)) begin
      q = 2'd1; f = 13'(r_q - 15'(e2b_pkg::QuarterTurn));
    end else begin
      q = 2'd0; f = 13'(r_q);
    end
    prod = 42'(f) * 42'(e2b_pkg::RadPerUnit) + 42'd512;
  end

  always_ff @(posedge clk_i) begin
    seed_o.x    <= e2b_pkg::GainQ30;
    seed_o.y    <= '0;
    seed_o.z    <= e2b_pkg::word_t'(prod >> 10);
    seed_o.quad <= q;
  end

endmodule

// File: rtl/e2b_cell.sv
// ---------------------------------------------------------------------------
// e2b_cell: one CORDIC rotation cell
// Holds one micro-rotation of one angle and hands it to the next cell.
// ---------------------------------------------------------------------------
module e2b_cell #(
  parameter int Idx = 0
) (
  input  logic          clk_i,
  input  e2b_pkg::rot_t rot_i,
  output e2b_pkg::rot_t rot_o
);

  e2b_pkg::word_t dx, dy, a;

  always_comb begin
    dx = rot_i.y >>> Idx;
    dy = rot_i.x >>> Idx;
    a  = e2b_pkg::atan_q30(5'(Idx));
  end

  always_ff @(posedge clk_i) begin
    rot_o.quad <= rot_i.quad;
    if (!rot_i.z[e2b_pkg::DW-1]) begin
      rot_o.x <= rot_i.x - dx;
      rot_o.y <= rot_i.y + dy;
      rot_o.z <= rot_i.z - a;
    end else begin
      rot_o.x <= rot_i.x + dx;
      rot_o.y <= rot_i.y - dy;
      rot_o.z <= rot_i.z + a;
    end
  end

endmodule

// File: rtl/e2b_sincos.sv
// ---------------------------------------------------------------------------
// e2b_sincos: sine and cosine of one angle
// Reduction stage, a row of CORDIC cells and the quadrant fix-up.
// ---------------------------------------------------------------------------
module e2b_sincos #(
  parameter int CordicSteps = e2b_pkg::CordicStepsDef
) (
  input  logic                            clk_i,
  input  logic signed [e2b_pkg::AngW-1:0] ang_i,
  output e2b_pkg::word_t                  sin_o,
  output e2b_pkg::word_t                  cos_o
);

  localparam int N = (CordicSteps < e2b_pkg::TabLen) ? CordicSteps : e2b_pkg::TabLen;

  e2b_pkg::rot_t row [N+1];

  e2b_prep u_prep (.clk_i(clk_i), .ang_i(ang_i), .seed_o(row[0]));

  for (genvar i = 0; i < N; i++) begin : g_cell
    e2b_cell #(.Idx(i)) u_cell (.clk_i(clk_i), .rot_i(row[i]), .rot_o(row[i+1]));
  end

  always_ff @(posedge clk_i) begin
    case (row[N].quad)
      2'd0: begin sin_o <= row[N].y;  cos_o <= row[N].x;  end
      2'd1: begin sin_o <= row[N].x;  cos_o <= -row[N].y; end
      2'd2: begin sin_o <= -row[N].y; cos_o <= -row[N].x; end
      default: begin sin_o <= -row[N].x; cos_o <= row[N].y; end
    endcase
  end

endmodule

// File: rtl/euler_to_basis_vectors.sv
// A request travels to done_o through two reduction stages, one cell per
// rotation step, the quadrant fix-up and three product stages. Throughput:
// one request per cycle; busy is never raised because the receiver cannot
// stall. Reset clears only the valid pipeline; the data path carries no
// reset.
// ---------------------------------------------------------------------------
// euler_to_basis_vectors: Euler angles to forward, right and up vectors
// Three CORDIC rows give sine and cosine of pitch, yaw and roll; a short
// product pipeline then forms the nine basis vector components.
// ---------------------------------------------------------------------------
module euler_to_basis_vectors #(
  parameter int CORDIC_STEPS  = e2b_pkg::CordicStepsDef,
  parameter int OUT_FRAC_BITS = e2b_pkg::OutFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] pitch_deg_i,
  input  logic signed [15:0] yaw_deg_i,
  input  logic signed [15:0] roll_deg_i,
  output logic        done_o,
  output logic signed [15:0] fwd_x_o,
  output logic signed [15:0] fwd_y_o,
  output logic signed [15:0] fwd_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o
);

  localparam int NSteps = (CORDIC_STEPS < e2b_pkg::TabLen) ? CORDIC_STEPS : e2b_pkg::TabLen;
  localparam int Lat    = NSteps + 6;
  localparam int Shift  = 30 - OUT_FRAC_BITS;

  typedef e2b_pkg::word_t w_t;

  // Requests are never refused: every stage moves on in every cycle.
  assign busy = 1'b0;

  logic [Lat-1:0] vld_q, vld_d;
  assign vld_d = {vld_q[Lat-2:0], start};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end
  assign done_o = vld_q[Lat-1];

  w_t sp, cp, sy, cy, sr, cr;

  e2b_sincos #(.CordicSteps(CORDIC_STEPS)) u_p (
    .clk_i(clk_i), .ang_i(pitch_deg_i), .sin_o(sp), .cos_o(cp)
  );
  e2b_sincos #(.CordicSteps(CORDIC_STEPS)) u_y (
    .clk_i(clk_i), .ang_i(yaw_deg_i), .sin_o(sy), .cos_o(cy)
  );
  e2b_sincos #(.CordicSteps(CORDIC_STEPS)) u_r (
    .clk_i(clk_i), .ang_i(roll_deg_i), .sin_o(sr), .cos_o(cr)
  );

  // First product stage: the pairwise products, plus sines and cosines
  // carried along for the second stage.
  w_t spcy_q, spsy_q, cpcy_q, cpsy_q, nsp_q, crsy_q, crcy_q, srsy_q, srcy_q;
  w_t srcp_q, crcp_q, sr1_q, cr1_q;
  always_ff @(posedge clk_i) begin
    spcy_q <= e2b_pkg::mulq(sp, cy);
    spsy_q <= e2b_pkg::mulq(sp, sy);
    cpcy_q <= e2b_pkg::mulq(cp, cy);
    cpsy_q <= e2b_pkg::mulq(cp, sy);
    nsp_q  <= -sp;
    crsy_q <= e2b_pkg::mulq(cr, sy);
    crcy_q <= e2b_pkg::mulq(cr, cy);
    srsy_q <= e2b_pkg::mulq(sr, sy);
    srcy_q <= e2b_pkg::mulq(sr, cy);
    srcp_q <= -e2b_pkg::mulq(sr, cp);
    crcp_q <= e2b_pkg::mulq(cr, cp);
    sr1_q  <= sr;
    cr1_q  <= cr;
  end

  // Second stage: the triple products and the sums, in Q30.
  w_t v_q [9];
  always_ff @(posedge clk_i) begin
    v_q[0] <= cpcy_q;
    v_q[1] <= cpsy_q;
    v_q[2] <= nsp_q;
    v_q[3] <= crsy_q - e2b_pkg::mulq(sr1_q, spcy_q);
    v_q[4] <= -e2b_pkg::mulq(sr1_q, spsy_q) - crcy_q;
    v_q[5] <= srcp_q;
    v_q[6] <= e2b_pkg::mulq(cr1_q, spcy_q) + srsy_q;
    v_q[7] <= e2b_pkg::mulq(cr1_q, spsy_q) - srcy_q;
    v_q[8] <= crcp_q;
  end

  // Output stage: round half up to the output fraction, then saturate.
  function automatic logic [15:0] to_out(input w_t v);
    w_t t, lim;
    t = v;
    lim = w_t'(1) <<< OUT_FRAC_BITS;
    if (Shift > 0) t = (v + (w_t'(1) <<< (Shift - 1))) >>> Shift;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t[15:0];
  endfunction

  logic [15:0] o_q [9];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) o_q[k] <= to_out(v_q[k]);
  end

  assign fwd_x_o   = o_q[0];
  assign fwd_y_o   = o_q[1];
  assign fwd_z_o   = o_q[2];
  assign right_x_o = o_q[3];
  assign right_y_o = o_q[4];
  assign right_z_o = o_q[5];
  assign up_x_o    = o_q[6];
  assign up_y_o    = o_q[7];
  assign up_z_o    = o_q[8];

endmodule

// File: dv/euler_to_basis_vectors_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_to_basis_vectors_tb: self-checking bench for the Euler basis block
// Drives angle requests through a gapped driver, predicts the nine vector
// components with a local CORDIC model and compares every strobed result.
// ---------------------------------------------------------------------------
module euler_to_basis_vectors_tb;

  // The block is stateless, so the prediction is a pure function of the
  // three angles. Results leave in request order, one per request.
  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
  } basis_t;

  localparam int StepsUsed  = (e2b_pkg::CordicStepsDef < e2b_pkg::TabLen) ?
                              e2b_pkg::CordicStepsDef : e2b_pkg::TabLen;
  localparam int FracBits   = e2b_pkg::OutFracBitsDef;
  localparam int LatencyCyc = e2b_pkg::CordicStepsDef + 7;
  localparam int WatchLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] pitch_deg_i = '0, yaw_deg_i = '0, roll_deg_i = '0;
  logic done_o;
  logic signed [15:0] fwd_x_o, fwd_y_o, fwd_z_o;
  logic signed [15:0] right_x_o, right_y_o, right_z_o;
  logic signed [15:0] up_x_o, up_y_o, up_z_o;

  angles_t pending_requests[$];
  basis_t  expected_bases[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      stimulus_done = 1'b0;
  bit      drain_hold = 1'b0;
  int      gap_left = 0;

  always #2 clk_i = ~clk_i;

  euler_to_basis_vectors DUT (
    .clk_i, .rst_ni, .start, .busy,
    .pitch_deg_i, .yaw_deg_i, .roll_deg_i,
    .done_o,
    .fwd_x_o, .fwd_y_o, .fwd_z_o,
    .right_x_o, .right_y_o, .right_z_o,
    .up_x_o, .up_y_o, .up_z_o
  );

  // Arctangent table in Q30, truncated, one entry per rotation step.
  function automatic longint atan_entry(input int i);
    longint tab[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return tab[i];
  endfunction

  function automatic longint q30_product(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Reduces the angle modulo a full turn, rotates the residual below a
  // quarter turn, and then moves sine and cosine into the right quadrant.
  task automatic angle_sin_cos(input logic signed [15:0] ang,
                               output longint s, output longint c);
    longint r, q, f, x, y, z, dx, dy;
    r = longint'(ang) % e2b_pkg::FullTurn;
    if (r < 0) r += e2b_pkg::FullTurn;
    q = r / e2b_pkg::QuarterTurn;
    f = r - q * e2b_pkg::QuarterTurn;
    z = (f * 64'sd299845282 + 64'sd512) >>> 10;
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < StepsUsed; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    case (q)
      0: begin s = y;  c = x;  end
      1: begin s = x;  c = -y; end
      2: begin s = -y; c = -x; end
      default: begin s = -x; c = y; end
    endcase
  endtask

  // Rounds Q30 half up to the output fraction and saturates at plus or
  // minus one.
  function automatic logic signed [15:0] to_component(input longint v);
    longint lim;
    int sh;
    sh = 30 - FracBits;
    lim = 64'sd1 <<< FracBits;
    if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  task automatic predict_basis(input angles_t a, output basis_t b);
    longint sp, cp, sy, cy, sr, cr, spcy, spsy;
    angle_sin_cos(a.pitch, sp, cp);
    angle_sin_cos(a.yaw, sy, cy);
    angle_sin_cos(a.roll, sr, cr);
    spcy = q30_product(sp, cy);
    spsy = q30_product(sp, sy);
    b.fx = to_component(q30_product(cp, cy));
    b.fy = to_component(q30_product(cp, sy));
    b.fz = to_component(-sp);
    b.rx = to_component(-q30_product(sr, spcy) + q30_product(cr, sy));
    b.ry = to_component(-q30_product(sr, spsy) - q30_product(cr, cy));
    b.rz = to_component(-q30_product(sr, cp));
    b.ux = to_component(q30_product(cr, spcy) + q30_product(sr, sy));
    b.uy = to_component(q30_product(cr, spsy) - q30_product(sr, cy));
    b.uz = to_component(q30_product(cr, cp));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Driver: requests change at the falling edge. A fresh gap is drawn for
  // every request; start is written once per step so it never glitches.
  always @(negedge clk_i) begin
    angles_t a;
    basis_t b;
    if (rst_ni) begin
      if (start && !busy) begin
        // The request went in at the last rising edge.
        gap_left = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (start && busy) begin
        start <= 1'b1;
      end else if (pending_requests.size() > 0 &&
                   !(drain_hold && expected_bases.size() > 0)) begin
        a = pending_requests.pop_front();
        predict_basis(a, b);
        expected_bases.push_back(b);
        pitch_deg_i <= a.pitch;
        yaw_deg_i <= a.yaw;
        roll_deg_i <= a.roll;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results are sampled at the rising edge that ends their cycle.
  always @(posedge clk_i) begin
    basis_t b;
    if (rst_ni) begin
      if (done_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done_o) begin
        if (expected_bases.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          b = expected_bases.pop_front();
          if (fwd_x_o !== b.fx) report_mismatch("fwd_x", fwd_x_o, b.fx);
          if (fwd_y_o !== b.fy) report_mismatch("fwd_y", fwd_y_o, b.fy);
          if (fwd_z_o !== b.fz) report_mismatch("fwd_z", fwd_z_o, b.fz);
          if (right_x_o !== b.rx) report_mismatch("right_x", right_x_o, b.rx);
          if (right_y_o !== b.ry) report_mismatch("right_y", right_y_o, b.ry);
          if (right_z_o !== b.rz) report_mismatch("right_z", right_z_o, b.rz);
          if (up_x_o !== b.ux) report_mismatch("up_x", up_x_o, b.ux);
          if (up_y_o !== b.uy) report_mismatch("up_y", up_y_o, b.uy);
          if (up_z_o !== b.uz) report_mismatch("up_z", up_z_o, b.uz);
        end
      end
    end
  end

  // Watchdog: ends the run if nothing is accepted or returned for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] random_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());                              // any pattern
      1: return 16'($urandom_range(0, 8) * 2880);             // octant points
      2: return 16'($urandom_range(0, 4) * 5760 + $urandom_range(0, 2) - 1);
      default: return 16'(int'($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  task automatic queue_request(input int p, input int y, input int r);
    angles_t a;
    a.pitch = 16'(p);
    a.yaw = 16'(y);
    a.roll = 16'(r);
    pending_requests.push_back(a);
  endtask

  initial begin
    int drain;
    // Directed requests: zero, quadrant boundaries, range extremes, values
    // that wrap beyond a full turn, and the extreme 16-bit patterns.
    queue_request(0, 0, 0);
    queue_request(23040, -23040, 23040);
    queue_request(-23040, 23040, -23040);
    queue_request(5760, 0, 0);
    queue_request(-5760, 5760, 11520);
    queue_request(11520, 17280, -5760);
    queue_request(17280, -11520, -17280);
    queue_request(5759, 5761, 11519);
    queue_request(-1, 1, 23039);
    queue_request(32767, -32768, 32767);
    queue_request(-32768, 32767, -32768);
    queue_request(-32767, 23041, -23041);
    queue_request(2880, 2880, 2880);
    queue_request(-2880, 8640, 14400);
    queue_request(16'h5555, 16'shAAAA, 16'h7FFF);
    queue_request(16'shAAAA, 16'h5555, 16'sh8000);
    queue_request(1920, -1920, 3840);
    queue_request(20160, 20160, -20160);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Let the directed part drain, then hold the sender before each request until every
    // expected result has come: the first random batch goes in one at a time, the second without the hold.
    wait (pending_requests.size() == 0);
    drain_hold = 1'b1;
    repeat (325) queue_request(random_angle(), random_angle(), random_angle());
    wait (expected_bases.size() == 0 && pending_requests.size() == 0);
    drain_hold = 1'b0;
    repeat (325) queue_request(random_angle(), random_angle(), random_angle());

    wait (pending_requests.size() == 0 && expected_bases.size() == 0);
    stimulus_done = 1'b1;
    drain = 0;
    while (drain < 2 * LatencyCyc) begin
      @(posedge clk_i);
      drain++;
    end
    if (error_count == 0 && expected_bases.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
